/* rtl/core/idll_pkg.sv */
// shared types, constants and request/status codes for the indexed doubly linked list
// no dependencies; imported by every module of the block
package idll_pkg;

    // store geometry
    localparam int NODE_COUNT = 256;
    localparam int VALUE_W    = 32;
    localparam int ID_W       = $clog2(NODE_COUNT);
    localparam int FRESH_W    = ID_W + 1;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = ((ID_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((5 * ID_W + VALUE_W + 7) / 8) * 8;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [FRESH_W-1:0]  t_fresh;
    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    // request kinds
    localparam t_req REQ_INS_AFTER  = 3'd0;
    localparam t_req REQ_INS_BEFORE = 3'd1;
    localparam t_req REQ_APPEND     = 3'd2;
    localparam t_req REQ_PREPEND    = 3'd3;
    localparam t_req REQ_DELETE     = 3'd4;
    localparam t_req REQ_READ       = 3'd5;

    // result status
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_BAD  = 2'd2;

    // write commands into the link and value memories
    typedef struct packed {
        logic   next_we;
        t_id    next_addr;
        t_id    next_data;
        logic   prev_we;
        t_id    prev_addr;
        t_id    prev_data;
        logic   val_we;
        t_id    val_addr;
        t_value val_data;
    } t_link_wr;

    // free stack commands
    typedef struct packed {
        logic pop;
        logic push;
        t_id  push_id;
    } t_free_op;

    // free stack status
    typedef struct packed {
        t_id    pop_id;
        logic   store_full;
        t_fresh fresh_next;
    } t_free_stat;

endpackage

/* rtl/core/idll_link_store.sv */
// next, prev and value memories of the list, one read port each with registered data
// the sentinel node lives in head/tail registers; depends on idll_pkg
module idll_link_store
    import idll_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_id      i_rd_addr,
    input  t_link_wr i_wr,
    output t_id      o_next,
    output t_id      o_prev,
    output t_value   o_value,
    output t_id      o_head,
    output t_id      o_tail
);

    t_id    next_mem [NODE_COUNT];
    t_id    prev_mem [NODE_COUNT];
    t_value val_mem  [NODE_COUNT];

    t_id    r_next_q;
    t_id    r_prev_q;
    t_value r_val_q;
    logic   r_rd_zero;
    t_id    r_head;
    t_id    r_tail;

    // registered reads
    always_ff @(posedge i_clk) begin
        r_next_q <= next_mem[i_rd_addr];
        r_prev_q <= prev_mem[i_rd_addr];
        r_val_q  <= val_mem[i_rd_addr];
    end

    // sentinel flag for the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_zero <= 1'b0;
        end else begin
            r_rd_zero <= (i_rd_addr == '0);
        end
    end

    // memory writes, node 0 excluded from the next and prev memories
    always_ff @(posedge i_clk) begin
        if (i_wr.next_we && i_wr.next_addr != '0) begin
            next_mem[i_wr.next_addr] <= i_wr.next_data;
        end
        if (i_wr.prev_we && i_wr.prev_addr != '0) begin
            prev_mem[i_wr.prev_addr] <= i_wr.prev_data;
        end
        if (i_wr.val_we) begin
            val_mem[i_wr.val_addr] <= i_wr.val_data;
        end
    end

    // sentinel links: first and last node
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_wr.next_we && i_wr.next_addr == '0) begin
                r_head <= i_wr.next_data;
            end
            if (i_wr.prev_we && i_wr.prev_addr == '0) begin
                r_tail <= i_wr.prev_data;
            end
        end
    end

    assign o_next  = r_rd_zero ? r_head : r_next_q;
    assign o_prev  = r_rd_zero ? r_tail : r_prev_q;
    assign o_value = r_rd_zero ? '0 : r_val_q;
    assign o_head  = r_head;
    assign o_tail  = r_tail;

endmodule

/* rtl/core/idll_free_stack.sv */
// free id stack in a memory plus the high-water counter for fresh ids
// hands out the next id to allocate; depends on idll_pkg
module idll_free_stack
    import idll_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_free_op   i_op,
    output t_free_stat o_stat
);

    t_id    free_mem [NODE_COUNT-1];
    t_id    r_count;
    t_fresh r_fresh;
    t_id    r_top;
    t_id    top_addr;

    assign top_addr = (r_count != '0) ? r_count - 1'b1 : '0;

    // top of stack, read every cycle
    always_ff @(posedge i_clk) begin
        r_top <= free_mem[top_addr];
    end

    // push of a freed id, dropped when the stack is full
    always_ff @(posedge i_clk) begin
        if (i_op.push && r_count < ID_W'(NODE_COUNT - 1)) begin
            free_mem[r_count] <= i_op.push_id;
        end
    end

    // stack depth and high-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fresh <= FRESH_W'(1);
        end else if (i_op.pop) begin
            if (r_count != '0) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_fresh <= r_fresh + 1'b1;
            end
        end else if (i_op.push && r_count < ID_W'(NODE_COUNT - 1)) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_stat.pop_id     = (r_count != '0) ? r_top : r_fresh[ID_W-1:0];
    assign o_stat.store_full = (r_count == '0) && (r_fresh == FRESH_W'(NODE_COUNT));
    assign o_stat.fresh_next = r_fresh;

endmodule

/* rtl/core/indexed_doubly_linked_list.sv */
// Indexed doubly linked list with free-id reuse.
// Requests arrive on the s_ stream: s_tuser carries the request kind (insert after,
// insert before, append, prepend, delete, read) and s_tdata the node id and value.
// Each request gives exactly one result on the m_ stream: m_tuser carries the status
// (ok, store full, bad id) and m_tdata the new id, read value and links, and the
// first and last node after the request.
// Sequencing: a request is taken only while the sequencer is idle.
// Delete, read, rejected and unused requests pass through accept, then lookup with
// write-back; a successful insert passes through accept, lookup of the target, read
// of its successor with the new node written, then relink of the neighbours. The
// insert steps are set by the single read port of the next-link memory, which must
// return the target and then its successor before the relink.
// Results sit in an output register; a new request is taken while a result waits.
// When the receiver stalls with the register full, the sequencer holds in its last
// step, with no memory write, until the register frees.
// Reset empties the list and the free stack; no clearing pass is needed, the
// sentinel links live in registers and no unwritten entry is ever read.
// Depends on idll_pkg, idll_link_store and idll_free_stack.
module indexed_doubly_linked_list
    import idll_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // node_id, item_value
    input  logic [REQ_W-1:0]    s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // result_id, read_value, read_next, read_prev,
                                           // first_id, last_id
    output logic [STATUS_W-1:0] m_tuser    // status
);

    // sequencer states
    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_LOOK     = 2'd1;
    localparam logic [1:0] S_LINK_NEW = 2'd2;
    localparam logic [1:0] S_LINK_OLD = 2'd3;

    logic [1:0] r_state, n_state;
    t_req       r_req;
    t_id        r_id;
    t_value     r_val;
    t_id        r_target;
    t_id        r_succ;
    t_id        r_new;

    logic       r_m_valid;
    t_id        r_out_result;
    t_value     r_out_rvalue;
    t_id        r_out_rnext;
    t_id        r_out_rprev;
    t_id        r_out_first;
    t_id        r_out_last;
    t_status    r_out_status;

    t_link_wr   lw;
    t_free_op   fop;
    t_free_stat fstat;
    t_id        rd_addr;
    t_id        link_next;
    t_id        link_prev;
    t_value     link_value;
    t_id        head;
    t_id        tail;

    logic       accept;
    logic       out_free;
    logic       load_out;
    logic       id_alloc;
    logic       is_ins;
    logic       bad;
    logic       ins_go;
    logic       del_go;
    t_id        target_c;
    t_id        n_result;
    t_value     n_rvalue;
    t_id        n_rnext;
    t_id        n_rprev;
    t_id        n_first;
    t_id        n_last;
    t_status    n_status;

    idll_link_store u_links (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (lw),
        .o_next    (link_next),
        .o_prev    (link_prev),
        .o_value   (link_value),
        .o_head    (head),
        .o_tail    (tail)
    );

    idll_free_stack u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (fop),
        .o_stat  (fstat)
    );

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;

    // request classification, valid once the lookup data is back
    assign id_alloc = {1'b0, r_id} < fstat.fresh_next;
    assign is_ins   = (r_req == REQ_INS_AFTER) || (r_req == REQ_INS_BEFORE) ||
                      (r_req == REQ_APPEND) || (r_req == REQ_PREPEND);

    always_comb begin
        target_c = '0;
        bad      = 1'b0;
        unique case (r_req)
            REQ_INS_AFTER: begin
                target_c = r_id;
                bad      = !id_alloc;
            end
            REQ_INS_BEFORE: begin
                target_c = link_prev;
                bad      = !id_alloc;
            end
            REQ_APPEND: begin
                target_c = tail;
            end
            REQ_PREPEND: begin
                target_c = '0;
            end
            REQ_DELETE: begin
                bad = (r_id == '0) || !id_alloc;
            end
            REQ_READ: begin
                bad = !id_alloc;
            end
            default: begin
                bad = 1'b0;
            end
        endcase
    end

    assign ins_go = is_ins && !bad && !fstat.store_full;
    assign del_go = (r_req == REQ_DELETE) && !bad;

    // sequencer: lookup and result, or for an insert lookup, then link the new node, then relink its neighbours
    always_comb begin
        n_state  = r_state;
        rd_addr  = r_id;
        lw       = '0;
        fop      = '0;
        load_out = 1'b0;
        n_result = '0;
        n_rvalue = '0;
        n_rnext  = '0;
        n_rprev  = '0;
        n_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = s_tdata[ID_W-1:0];
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (ins_go) begin
                    rd_addr = target_c;
                    n_state = S_LINK_NEW;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (bad) begin
                        n_status = ST_BAD;
                    end else if (is_ins) begin
                        n_status = ST_FULL;
                    end else if (r_req == REQ_READ) begin
                        n_rvalue = link_value;
                        n_rnext  = link_next;
                        n_rprev  = link_prev;
                    end
                    if (del_go) begin
                        lw.next_we   = 1'b1;
                        lw.next_addr = link_prev;
                        lw.next_data = link_next;
                        lw.prev_we   = 1'b1;
                        lw.prev_addr = link_next;
                        lw.prev_data = link_prev;
                        fop.push     = 1'b1;
                        fop.push_id  = r_id;
                    end
                end
            end
            S_LINK_NEW: begin
                lw.next_we   = 1'b1;
                lw.next_addr = fstat.pop_id;
                lw.next_data = link_next;
                lw.prev_we   = 1'b1;
                lw.prev_addr = fstat.pop_id;
                lw.prev_data = r_target;
                lw.val_we    = 1'b1;
                lw.val_addr  = fstat.pop_id;
                lw.val_data  = r_val;
                fop.pop      = 1'b1;
                n_state      = S_LINK_OLD;
            end
            S_LINK_OLD: begin
                if (out_free) begin
                    lw.next_we   = 1'b1;
                    lw.next_addr = r_target;
                    lw.next_data = r_new;
                    lw.prev_we   = 1'b1;
                    lw.prev_addr = r_succ;
                    lw.prev_data = r_new;
                    load_out     = 1'b1;
                    n_result     = r_new;
                    n_state      = S_IDLE;
                end
            end
        endcase
        // first and last node as they stand after this cycle's writes
        n_first = (lw.next_we && lw.next_addr == '0) ? lw.next_data : head;
        n_last  = (lw.prev_we && lw.prev_addr == '0) ? lw.prev_data : tail;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request payload and working ids
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= s_tuser;
            r_id  <= s_tdata[ID_W-1:0];
            r_val <= s_tdata[ID_W +: VALUE_W];
        end
        if (r_state == S_LOOK && ins_go) begin
            r_target <= target_c;
        end
        if (r_state == S_LINK_NEW) begin
            r_succ <= link_next;
            r_new  <= fstat.pop_id;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_result <= n_result;
            r_out_rvalue <= n_rvalue;
            r_out_rnext  <= n_rnext;
            r_out_rprev  <= n_rprev;
            r_out_first  <= n_first;
            r_out_last   <= n_last;
            r_out_status <= n_status;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_DATA_W'({r_out_last, r_out_first, r_out_rprev, r_out_rnext,
                                 r_out_rvalue, r_out_result});
    assign m_tuser  = r_out_status;

    // a taken request always goes to lookup
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("request taken but sequencer not in lookup");

    // no allocation from a full store
    a_pop_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fop.pop |-> !fstat.store_full)
        else $error("id allocated from a full store");

    // the sentinel is never handed out as a new node
    a_new_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_NEW) |-> (fstat.pop_id != '0))
        else $error("sentinel id allocated");

    // neighbour relink only together with its result
    a_relink_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_OLD && lw.next_we) |-> load_out)
        else $error("relink without result");

    // a full-store result carries no id
    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_out_status == ST_FULL) |-> (r_out_result == '0))
        else $error("full status with a new id");

endmodule

/* test/indexed_doubly_linked_list_tb.sv */
// self-checking testbench for the indexed doubly linked list: directed and random requests
// with a list tracker that predicts every result; depends on idll_pkg and the block itself
module indexed_doubly_linked_list_tb;
    import idll_pkg::*;

    // request codes the block leaves unused
    localparam t_req REQ_UNUSED_A = 3'd6;
    localparam t_req REQ_UNUSED_B = 3'd7;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES  = 8;

    // one result as the block should report it
    typedef struct {
        t_id     new_id;
        t_value  value;
        t_id     succ;
        t_id     pred;
        t_id     head;
        t_id     tail;
        t_status status;
    } list_result_t;

    // tracks the list, the free stack and the high-water mark; queues expected results
    class list_scoreboard;
        t_id          next_of  [NODE_COUNT];
        t_id          prev_of  [NODE_COUNT];
        t_value       value_of [NODE_COUNT];
        t_id          free_ids [NODE_COUNT-1];
        int           free_depth;
        int           fresh_id;
        list_result_t pending_results[$];
        int           fail_count;
        int           checked_count;
        int           insert_count;
        int           delete_count;
        int           read_count;
        int           bad_count;
        int           full_count;
        int           dropped_pushes;

        function new();
            foreach (next_of[i]) begin
                next_of[i]  = '0;
                prev_of[i]  = '0;
                value_of[i] = '0;
            end
            foreach (free_ids[i]) free_ids[i] = '0;
            free_depth     = 0;
            fresh_id       = 1;
            fail_count     = 0;
            checked_count  = 0;
            insert_count   = 0;
            delete_count   = 0;
            read_count     = 0;
            bad_count      = 0;
            full_count     = 0;
            dropped_pushes = 0;
        endfunction

        function bit is_allocated(t_id id);
            return int'(id) < fresh_id;
        endfunction

        // take an id (freed first, then fresh) and splice it in after target; 0 when full
        function t_id link_new_node(t_id target, t_value val);
            t_id n;
            t_id succ;
            if (free_depth > 0) begin
                free_depth--;
                n = free_ids[free_depth];
            end else if (fresh_id < NODE_COUNT) begin
                n = t_id'(fresh_id);
                fresh_id++;
            end else begin
                return '0;
            end
            value_of[n]  = val;
            succ         = next_of[target];
            next_of[n]   = succ;
            prev_of[n]   = target;
            prev_of[succ] = n;
            next_of[target] = n;
            return n;
        endfunction

        // unlink with whatever links the node holds, stale or not
        function void unlink_node(t_id id);
            t_id p;
            t_id s;
            p          = prev_of[id];
            s          = next_of[id];
            next_of[p] = s;
            prev_of[s] = p;
            if (free_depth < NODE_COUNT - 1) begin
                free_ids[free_depth] = id;
                free_depth++;
            end else begin
                dropped_pushes++;
            end
        endfunction

        // apply one accepted request and queue the result it should give
        function void note_request(t_req kind, t_id id, t_value val);
            list_result_t r;
            bit           do_insert;
            t_id          target;
            r         = '{default: '0};
            r.status  = ST_OK;
            do_insert = 1'b0;
            target    = '0;
            case (kind)
                REQ_INS_AFTER, REQ_INS_BEFORE: begin
                    if (!is_allocated(id)) begin
                        r.status = ST_BAD;
                    end else begin
                        target    = (kind == REQ_INS_AFTER) ? id : prev_of[id];
                        do_insert = 1'b1;
                    end
                end
                REQ_APPEND: begin
                    target    = prev_of[0];
                    do_insert = 1'b1;
                end
                REQ_PREPEND: begin
                    target    = '0;
                    do_insert = 1'b1;
                end
                REQ_DELETE: begin
                    delete_count++;
                    if (id == '0 || !is_allocated(id)) r.status = ST_BAD;
                    else unlink_node(id);
                end
                REQ_READ: begin
                    read_count++;
                    if (!is_allocated(id)) begin
                        r.status = ST_BAD;
                    end else begin
                        r.value = value_of[id];
                        r.succ  = next_of[id];
                        r.pred  = prev_of[id];
                    end
                end
                default: ;
            endcase
            if (do_insert) begin
                insert_count++;
                r.new_id = link_new_node(target, val);
                if (r.new_id == '0) r.status = ST_FULL;
            end
            if (r.status == ST_BAD) bad_count++;
            if (r.status == ST_FULL) full_count++;
            r.head = next_of[0];
            r.tail = prev_of[0];
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void report_mismatch(string what, logic [VALUE_W-1:0] got,
                                      logic [VALUE_W-1:0] want);
            $display("mismatch at result %0d: %s got %0h, expected %0h",
                     checked_count, what, got, want);
            fail_count++;
        endfunction

        // unpack one result and compare it with the oldest expectation
        function void check_result(logic [M_DATA_W-1:0] data, logic [STATUS_W-1:0] user);
            list_result_t want;
            list_result_t got;
            got.new_id = data[0 +: ID_W];
            got.value  = data[ID_W +: VALUE_W];
            got.succ   = data[ID_W + VALUE_W +: ID_W];
            got.pred   = data[2*ID_W + VALUE_W +: ID_W];
            got.head   = data[3*ID_W + VALUE_W +: ID_W];
            got.tail   = data[4*ID_W + VALUE_W +: ID_W];
            got.status = user;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding",
                                VALUE_W'(got.new_id), '0);
                return;
            end
            want = pending_results.pop_front();
            checked_count++;
            if (got.new_id !== want.new_id)
                report_mismatch("result_id", VALUE_W'(got.new_id), VALUE_W'(want.new_id));
            if (got.value  !== want.value)  report_mismatch("read_value", got.value, want.value);
            if (got.succ   !== want.succ)
                report_mismatch("read_next", VALUE_W'(got.succ), VALUE_W'(want.succ));
            if (got.pred   !== want.pred)
                report_mismatch("read_prev", VALUE_W'(got.pred), VALUE_W'(want.pred));
            if (got.head   !== want.head)
                report_mismatch("first_id", VALUE_W'(got.head), VALUE_W'(want.head));
            if (got.tail   !== want.tail)
                report_mismatch("last_id", VALUE_W'(got.tail), VALUE_W'(want.tail));
            if (got.status !== want.status)
                report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
        endfunction
    endclass

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // node_id, item_value
    logic [REQ_W-1:0]    s_tuser  = '0;   // req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // result_id, read_value, read_next, read_prev,
                                    // first_id, last_id
    logic [STATUS_W-1:0] m_tuser;   // status

    list_scoreboard board;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    indexed_doubly_linked_list DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    // hard stop
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timed out with %0d results outstanding", board.pending_results.size());
        $display("FAILURE");
        $finish;
    end

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // one request, with random idle cycles in front; valid stays up between back-to-back requests
    task automatic send_request(input t_req kind, input t_id id, input t_value val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({val, id});
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_request(kind, id, val);
    endtask

    // sender holds off until every outstanding result is back or its guard runs out
    task automatic pause_until_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic t_value pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return t_value'($urandom);
    endfunction

    // mostly allocated targets, the rest anywhere in the id range
    function automatic t_id pick_target(input int allocated_pct);
        if ($urandom_range(0, 99) < allocated_pct)
            return t_id'($urandom_range(0, board.fresh_id - 1));
        return t_id'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic t_id pick_victim();
        if (board.fresh_id > 1 && $urandom_range(0, 99) < 90)
            return t_id'($urandom_range(1, board.fresh_id - 1));
        return t_id'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic t_req pick_insert_kind();
        case ($urandom_range(0, 3))
            0:       return REQ_INS_AFTER;
            1:       return REQ_INS_BEFORE;
            2:       return REQ_APPEND;
            default: return REQ_PREPEND;
        endcase
    endfunction

    // mixed traffic: inserts, deletes, reads and a little noise on unused codes
    task automatic random_request(input int insert_pct);
        int   roll;
        t_req kind;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)           kind = pick_insert_kind();
        else if (roll < insert_pct + 20) kind = REQ_DELETE;
        else if (roll < 96)              kind = REQ_READ;
        else                             kind = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
        if (kind == REQ_DELETE) send_request(kind, pick_victim(), pick_value());
        else                    send_request(kind, pick_target(88), pick_value());
    endtask

    initial begin
        int burst;
        board = new();

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, bad ids, every insert flavour, double delete, stale read
        set_idling(0, 0);
        send_request(REQ_READ,       8'd0,   32'h0);
        send_request(REQ_DELETE,     8'd0,   32'h0);
        send_request(REQ_DELETE,     8'd1,   32'h0);
        send_request(REQ_INS_AFTER,  8'd5,   32'h1234_5678);
        send_request(REQ_INS_BEFORE, 8'd255, 32'hFFFF_FFFF);
        send_request(REQ_READ,       8'd255, 32'h0);
        send_request(REQ_APPEND,     8'd0,   32'h0000_0000);
        send_request(REQ_PREPEND,    8'd255, 32'hFFFF_FFFF);
        send_request(REQ_INS_AFTER,  8'd1,   32'hA5A5_A5A5);
        send_request(REQ_INS_BEFORE, 8'd1,   32'h5A5A_5A5A);
        send_request(REQ_INS_AFTER,  8'd0,   32'h0000_0001);
        send_request(REQ_INS_BEFORE, 8'd0,   32'h8000_0000);
        send_request(REQ_READ,       8'd1,   32'h0);
        send_request(REQ_READ,       8'd6,   32'h0);
        send_request(REQ_DELETE,     8'd3,   32'h0);
        send_request(REQ_DELETE,     8'd3,   32'h0);
        send_request(REQ_READ,       8'd3,   32'h0);
        send_request(REQ_APPEND,     8'd0,   32'hDEAD_BEEF);
        send_request(REQ_APPEND,     8'd0,   32'hCAFE_F00D);
        send_request(REQ_READ,       8'd3,   32'h0);
        send_request(REQ_UNUSED_A,   8'd255, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED_B,   8'd170, 32'h5555_5555);
        pause_until_drained();

        // random phases under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(46, 0);
                2:       set_idling(0, 46);
                default: set_idling(9, 9);
            endcase
            repeat (30) random_request(55);
            pause_until_drained();
        end

        // fill the store until no id is left, then knock on it a few times
        set_idling(0, 46);
        while (board.fresh_id < NODE_COUNT || board.free_depth > 0)
            send_request(pick_insert_kind(), pick_target(100), pick_value());
        repeat (3) send_request(pick_insert_kind(), pick_target(100), pick_value());
        pause_until_drained();

        // delete storm, repeats included, until the free stack overflows
        set_idling(9, 9);
        burst = 0;
        while (board.dropped_pushes < 2 && burst < 400) begin
            if ($urandom_range(0, 7) == 0) send_request(REQ_READ, pick_target(100), pick_value());
            else                           send_request(REQ_DELETE, pick_victim(), pick_value());
            burst++;
        end
        pause_until_drained();

        // reuse of the overflowed stack
        set_idling(46, 46);
        repeat (30) random_request(60);

        // wind down
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending_results.size() != 0)
            board.report_mismatch("results never arrived", board.pending_results.size(), '0);

        $display("checked %0d results: %0d inserts, %0d deletes, %0d reads, %0d bad ids",
                 board.checked_count, board.insert_count, board.delete_count,
                 board.read_count, board.bad_count);
        $display("store full %0d times, free stack overflowed %0d times",
                 board.full_count, board.dropped_pushes);
        if (board.fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/idll_pkg.sv
rtl/core/idll_link_store.sv
rtl/core/idll_free_stack.sv
rtl/core/indexed_doubly_linked_list.sv
test/indexed_doubly_linked_list_tb.sv
